// ===== rtl/mfap_pkg.sv =====
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared types and constants of the max-flow augmenting path engine.
// ----------------------------------------------------------------------------
package mfap_pkg;

   localparam int VTX_W        = 6;
   localparam int CAP_W        = 24;
   localparam int FLOW_W       = 32;
   localparam int NUM_VERTICES = 64;
   localparam int BN_W         = 30;
   localparam logic [BN_W-1:0] NO_PATH_LIMIT = 30'd1000000000;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_SOLVE = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [VTX_W-1:0] first_vertex;
      logic [VTX_W-1:0] second_vertex;
      logic [CAP_W-1:0] edge_capacity;
   } req_type;

   typedef struct packed {
      logic [FLOW_W-1:0] total_flow;
      logic              edges_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BFS_INIT,
      ST_DEQ,
      ST_DEQ_WAIT,
      ST_SCAN,
      ST_BN_PAR,
      ST_BN_ROW,
      ST_BN_EVAL,
      ST_PU_PAR,
      ST_PU_ROW,
      ST_PU_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic solve_load;
      logic bfs_init;
      logic deq_issue;
      logic deq_load;
      logic scan;
      logic walk_start;
      logic walk_rewind;
      logic row_issue;
      logic walk_min;
      logic walk_push;
      logic total_add;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic scan_done;
      logic dst_seen;
      logic at_src;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/mfap_ram.sv =====
// ----------------------------------------------------------------------------
// mfap_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mfap_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfap_ctrl
// Sequencer: item decode, breadth-first search, bottleneck walk, push walk.
// ----------------------------------------------------------------------------
module mfap_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mfap_pkg::req_type    req_data,
   input  mfap_pkg::status_type status,
   output mfap_pkg::cmd_type    cmd
);
   import mfap_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_SOLVE) begin
               if (req_data.first_vertex == req_data.second_vertex) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_BFS_INIT;
               end
            end
         end
         ST_BFS_INIT: state_in = ST_DEQ;
         ST_DEQ: begin
            if (!status.queue_empty) begin
               state_in = ST_DEQ_WAIT;
            end else if (status.dst_seen) begin
               state_in = ST_BN_PAR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DEQ_WAIT: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DEQ;
            end
         end
         ST_BN_PAR:  state_in = ST_BN_ROW;
         ST_BN_ROW:  state_in = ST_BN_EVAL;
         ST_BN_EVAL: state_in = status.at_src ? ST_PU_PAR : ST_BN_PAR;
         ST_PU_PAR:  state_in = ST_PU_ROW;
         ST_PU_ROW:  state_in = ST_PU_EVAL;
         ST_PU_EVAL: state_in = status.at_src ? ST_BFS_INIT : ST_PU_PAR;
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.clear      = accept && (req_data.operation == OP_CLEAR);
            cmd.add        = accept && (req_data.operation == OP_ADD);
            cmd.solve_load = accept && (req_data.operation == OP_SOLVE);
         end
         ST_BFS_INIT: cmd.bfs_init = 1'b1;
         ST_DEQ: begin
            cmd.deq_issue  = !status.queue_empty;
            cmd.walk_start = status.queue_empty && status.dst_seen;
         end
         ST_DEQ_WAIT: cmd.deq_load = 1'b1;
         ST_SCAN:     cmd.scan = 1'b1;
         ST_BN_PAR:   ;
         ST_BN_ROW:   cmd.row_issue = 1'b1;
         ST_BN_EVAL: begin
            cmd.walk_min    = 1'b1;
            cmd.walk_rewind = status.at_src;
         end
         ST_PU_PAR:   ;
         ST_PU_ROW:   cmd.row_issue = 1'b1;
         ST_PU_EVAL: begin
            cmd.walk_push = 1'b1;
            cmd.total_add = status.at_src;
         end
         ST_FINISH:   cmd.rsp_load = !status.rsp_busy;
         default:     ;
      endcase
   end

   // a search always ends on an empty queue before any walk starts
   a_walk_after_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ && state_in == ST_BN_PAR) |-> status.queue_empty)
      else $error("walk started with search pending");

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == ST_IDLE)
      else $error("result load did not return to idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !cmd.add && !cmd.clear && !cmd.solve_load)
      else $error("item decoded during search");

endmodule

// ===== rtl/mfap_dp.sv =====
// ----------------------------------------------------------------------------
// mfap_dp
// Datapath: edge and residual stores, search queue, parent table, visited
// marks, bottleneck and flow accumulation, result register.
// ----------------------------------------------------------------------------
module mfap_dp #(
   parameter int MAX_EDGES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfap_pkg::cmd_type    cmd,
   input  mfap_pkg::req_type    req_data,
   output mfap_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mfap_pkg::rsp_type    rsp_data
);
   import mfap_pkg::*;

   localparam int ROW_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int ENT_W  = ROW_W + 1;
   localparam int QCNT_W = VTX_W + 1;

   // edge count and dropped flag
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic             table_full;

   assign table_full = (count_ff == CNT_W'(MAX_EDGES));

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.add) begin
         if (table_full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // solve registers
   logic [VTX_W-1:0] src_ff, src_in, dst_ff, dst_in;
   assign src_in = cmd.solve_load ? req_data.first_vertex  : src_ff;
   assign dst_in = cmd.solve_load ? req_data.second_vertex : dst_ff;

   // edge rows: {tail, head} of the forward entry; backward entry is swapped
   logic [ROW_W-1:0]       row_rd_addr;
   logic [2*VTX_W-1:0]     th_rd;
   logic [2*CAP_W-1:0]     res_rd;
   logic                   res_wr_en;
   logic [ROW_W-1:0]       res_wr_addr;
   logic [2*CAP_W-1:0]     res_wr_data;
   logic                   add_wr;

   assign add_wr = cmd.add && !table_full;

   // scan pipeline
   logic [CNT_W-1:0] scan_row_ff, scan_row_in;
   logic             issued_ff, issued_in;
   logic [ROW_W-1:0] eval_row_ff, eval_row_in;
   logic [VTX_W-1:0] u_ff, u_in;

   // queue and parent table
   logic [QCNT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [VTX_W-1:0]  q_rd;
   logic              q_wr_en;
   logic [VTX_W-1:0]  q_wr_addr, q_wr_data;
   logic [ENT_W-1:0]  par_rd;

   logic [NUM_VERTICES-1:0] vis_ff, vis_in;

   // walk registers
   logic [VTX_W-1:0]  v_ff, v_in;
   logic [ENT_W-1:0]  e_ff, e_in;
   logic [BN_W-1:0]   bn_ff, bn_in;
   logic [FLOW_W-1:0] total_ff, total_in;

   // entry evaluation during scan
   logic [VTX_W-1:0] row_tail, row_head;
   logic [CAP_W-1:0] res_fwd, res_bwd;
   logic             fwd_hit, bwd_hit, eval_hit;
   logic [VTX_W-1:0] new_v;

   assign row_tail = th_rd[2*VTX_W-1:VTX_W];
   assign row_head = th_rd[VTX_W-1:0];
   assign res_fwd  = res_rd[CAP_W-1:0];
   assign res_bwd  = res_rd[2*CAP_W-1:CAP_W];

   assign fwd_hit  = cmd.scan && issued_ff && (row_tail == u_ff) && (res_fwd != '0)
                     && !vis_ff[row_head];
   assign bwd_hit  = cmd.scan && issued_ff && (row_head == u_ff) && (res_bwd != '0)
                     && !vis_ff[row_tail];
   assign eval_hit = fwd_hit || bwd_hit;
   assign new_v    = fwd_hit ? row_head : row_tail;

   always_comb begin
      scan_row_in = scan_row_ff;
      issued_in   = 1'b0;
      eval_row_in = eval_row_ff;
      if (cmd.deq_load) begin
         scan_row_in = '0;
      end else if (cmd.scan && (scan_row_ff != count_ff)) begin
         scan_row_in = scan_row_ff + CNT_W'(1);
         issued_in   = 1'b1;
         eval_row_in = scan_row_ff[ROW_W-1:0];
      end
   end

   assign u_in = cmd.deq_load ? q_rd : u_ff;

   assign row_rd_addr = cmd.row_issue ? par_rd[ENT_W-1:1] : scan_row_ff[ROW_W-1:0];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (cmd.bfs_init) begin
         head_in = '0;
         tail_in = QCNT_W'(1);
      end else begin
         if (cmd.deq_issue) begin
            head_in = head_ff + QCNT_W'(1);
         end
         if (eval_hit) begin
            tail_in = tail_ff + QCNT_W'(1);
         end
      end
   end

   assign q_wr_en   = cmd.bfs_init || eval_hit;
   assign q_wr_addr = cmd.bfs_init ? '0 : tail_ff[VTX_W-1:0];
   assign q_wr_data = cmd.bfs_init ? src_ff : new_v;

   always_comb begin
      vis_in = vis_ff;
      if (cmd.bfs_init) begin
         vis_in         = '0;
         vis_in[src_ff] = 1'b1;
      end else if (eval_hit) begin
         vis_in[new_v] = 1'b1;
      end
   end

   // path walk: selected entry of the row read at parent_edge[v]
   logic [CAP_W-1:0] ent_res;
   logic [VTX_W-1:0] ent_tail;
   logic [CAP_W-1:0] push_amt;
   logic [FLOW_W:0]  total_sum;

   assign ent_res   = e_ff[0] ? res_bwd  : res_fwd;
   assign ent_tail  = e_ff[0] ? row_head : row_tail;
   assign push_amt  = bn_ff[CAP_W-1:0];
   assign total_sum = {1'b0, total_ff} + (FLOW_W + 1)'(push_amt);

   always_comb begin
      v_in     = v_ff;
      e_in     = cmd.row_issue ? par_rd : e_ff;
      bn_in    = bn_ff;
      total_in = total_ff;
      if (cmd.solve_load) begin
         total_in = '0;
      end
      if (cmd.walk_start) begin
         v_in  = dst_ff;
         bn_in = NO_PATH_LIMIT;
      end
      if (cmd.walk_min) begin
         v_in = ent_tail;
         if (BN_W'(ent_res) < bn_ff) begin
            bn_in = BN_W'(ent_res);
         end
      end
      if (cmd.walk_push) begin
         v_in = ent_tail;
      end
      if (cmd.walk_rewind) begin
         v_in = dst_ff;
      end
      if (cmd.total_add) begin
         total_in = total_sum[FLOW_W] ? '1 : total_sum[FLOW_W-1:0];
      end
   end

   always_comb begin
      res_wr_en   = add_wr || cmd.walk_push;
      res_wr_addr = count_ff[ROW_W-1:0];
      res_wr_data = {{CAP_W{1'b0}}, req_data.edge_capacity};
      if (cmd.walk_push) begin
         res_wr_addr = e_ff[ENT_W-1:1];
         if (e_ff[0]) begin
            res_wr_data = {res_bwd - push_amt, res_fwd + push_amt};
         end else begin
            res_wr_data = {res_bwd + push_amt, res_fwd - push_amt};
         end
      end
   end

   mfap_ram #(.WIDTH(2*VTX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (add_wr),
      .wr_addr (count_ff[ROW_W-1:0]),
      .wr_data ({req_data.first_vertex, req_data.second_vertex}),
      .rd_addr (row_rd_addr),
      .rd_data (th_rd)
   );

   mfap_ram #(.WIDTH(2*CAP_W), .DEPTH(MAX_EDGES)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_wr_en),
      .wr_addr (res_wr_addr),
      .wr_data (res_wr_data),
      .rd_addr (row_rd_addr),
      .rd_data (res_rd)
   );

   mfap_ram #(.WIDTH(VTX_W), .DEPTH(NUM_VERTICES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (head_ff[VTX_W-1:0]),
      .rd_data (q_rd)
   );

   mfap_ram #(.WIDTH(ENT_W), .DEPTH(NUM_VERTICES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (eval_hit),
      .wr_addr (new_v),
      .wr_data ({eval_row_ff, bwd_hit}),
      .rd_addr (v_ff),
      .rd_data (par_rd)
   );

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.total_flow    = total_ff;
         rsp_data_in.edges_dropped = dropped_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         issued_ff    <= 1'b0;
         vis_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         issued_ff    <= issued_in;
         vis_ff       <= vis_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      scan_row_ff <= scan_row_in;
      eval_row_ff <= eval_row_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      bn_ff       <= bn_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.queue_empty = (head_ff == tail_ff);
   assign status.scan_done   = (scan_row_ff == count_ff) && !issued_ff;
   assign status.dst_seen    = vis_ff[dst_ff];
   assign status.at_src      = (ent_tail == src_ff);
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count above table size");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      eval_hit |-> tail_ff < QCNT_W'(NUM_VERTICES))
      else $error("search queue overflow");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && !dropped_ff)
      else $error("clear left edges behind");

   // every residual on a found path is positive
   a_bottleneck_positive: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_min |=> bn_ff != '0)
      else $error("zero bottleneck on path");

endmodule

// ===== rtl/max_flow_augmenting_path.sv =====
// ----------------------------------------------------------------------------
// max_flow_augmenting_path
// Edge loader and breadth-first augmenting path maximum flow solver.
// ----------------------------------------------------------------------------
// Input beats on req_* carry an operation: clear graph, add edge, or solve
// from first_vertex (source) to second_vertex (sink). Only a solve returns a
// beat on rsp_*, carrying total_flow and the sticky edges_dropped flag.
// Clear and add edge may stream every cycle while no solve is in progress.
// A solve holds req_ready low until its result is registered: each search
// sets up the queue and then, for every vertex taken from the queue, reads
// every stored edge row, one per cycle from the edge and residual RAMs;
// each augmenting path found is then walked twice, for the bottleneck and
// for the push. Source equal to sink skips the search. The result sits in
// an output register; a stalled receiver holds it while clears and adds
// are still taken, and a new solve waits at its end until the previous
// beat has gone. Reset empties the graph and drops any pending result;
// the stores need no clearing pass.
// ----------------------------------------------------------------------------
module max_flow_augmenting_path #(
   parameter int MAX_EDGES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfap_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfap_pkg::rsp_type rsp_data
);
   import mfap_pkg::*;

   cmd_type    cmd;
   status_type status;

   mfap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   mfap_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-flow augmenting path engine.
// ----------------------------------------------------------------------------
// Directed cases run first; random graphs are then loaded edge by edge and
// solved between random source and sink pairs. An internal Edmonds-Karp
// predictor tracks the residual graph and queues the expected flow of each
// solve; the scoreboard checks every response beat against it in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mfap_pkg::*;

   localparam int EDGES     = 256;
   localparam int MAX_CYCLE = 3000000;

   // --------------------------------------------------------------------------
   // Flow predictor and expected-result queue
   // --------------------------------------------------------------------------
   class flow_scoreboard;
      logic [VTX_W-1:0] tail_v [2*EDGES];
      logic [VTX_W-1:0] head_v [2*EDGES];
      logic [CAP_W-1:0] resid  [2*EDGES];
      int               edge_cnt;
      bit               dropped;
      rsp_type          pending_q[$];
      int               errors;

      function new();
         edge_cnt = 0;
         dropped  = 0;
         errors   = 0;
      endfunction

      // breadth-first search; fills parent edge per vertex
      function bit find_route(int src, int dst, ref int par[NUM_VERTICES]);
         bit seen[NUM_VERTICES];
         int q[$];
         int u;
         int v;
         foreach (seen[i]) seen[i] = 0;
         seen[src] = 1;
         q = {q, src};
         while (q.size() > 0) begin
            u = q.pop_front();
            for (int e = 0; e < 2*edge_cnt; e++) begin
               v = head_v[e];
               if (tail_v[e] == u && resid[e] != 0 && !seen[v]) begin
                  seen[v] = 1;
                  par[v] = e;
                  q = {q, v};
               end
            end
         end
         return seen[dst];
      endfunction

      function logic [FLOW_W-1:0] solve_flow(int src, int dst);
         longint total;
         int par[NUM_VERTICES];
         int v;
         int e;
         int bneck;
         total = 0;
         if (src == dst) return '0;
         while (find_route(src, dst, par)) begin
            bneck = 1000000000;
            v = dst;
            while (v != src) begin
               e = par[v];
               if (resid[e] < bneck) bneck = resid[e];
               v = tail_v[e];
            end
            v = dst;
            while (v != src) begin
               e = par[v];
               resid[e]     = resid[e] - bneck;
               resid[e ^ 1] = resid[e ^ 1] + bneck;
               v = tail_v[e];
            end
            total += bneck;
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
         end
         return total[FLOW_W-1:0];
      endfunction

      function void note_req(req_type r);
         rsp_type x;
         case (r.operation)
            OP_CLEAR: begin
               edge_cnt = 0;
               dropped  = 0;
            end
            OP_ADD: begin
               if (edge_cnt >= EDGES) begin
                  dropped = 1;
               end else begin
                  tail_v[2*edge_cnt]   = r.first_vertex;
                  head_v[2*edge_cnt]   = r.second_vertex;
                  resid[2*edge_cnt]    = r.edge_capacity;
                  tail_v[2*edge_cnt+1] = r.second_vertex;
                  head_v[2*edge_cnt+1] = r.first_vertex;
                  resid[2*edge_cnt+1]  = '0;
                  edge_cnt++;
               end
            end
            OP_SOLVE: begin
               x.total_flow    = solve_flow(r.first_vertex, r.second_vertex);
               x.edges_dropped = dropped;
               pending_q = {pending_q, x};
            end
            default: ;
         endcase
      endfunction

      task check_rsp(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            report("response with nothing expected");
            return;
         end
         want = pending_q.pop_front();
         if (got.total_flow !== want.total_flow)
            report($sformatf("total_flow got %0d want %0d", got.total_flow,
                             want.total_flow));
         if (got.edges_dropped !== want.edges_dropped)
            report($sformatf("edges_dropped got %0b want %0b", got.edges_dropped,
                             want.edges_dropped));
      endtask

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   flow_scoreboard sb;
   int  cycle = 0;
   bit  rsp_hold;

   max_flow_augmenting_path #(.MAX_EDGES(EDGES)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("max_flow_augmenting_path: mismatch");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Request driver
   // --------------------------------------------------------------------------
   // valid drops only during a gap, so a back-to-back beat keeps it high
   task automatic send_beat(logic [1:0] op, int a, int b, int cap);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, first_vertex: a[VTX_W-1:0],
                     second_vertex: b[VTX_W-1:0], edge_capacity: cap[CAP_W-1:0]};
      do @(posedge clock); while (!req_ready);
      sb.note_req(req_data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
   endtask

   function automatic int rand_cap();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return 24'hFFFFFF;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   // small graph with random content on nv vertices, then a few solves
   task automatic graph_round(int nv, int ne, int nsolve);
      int base;
      base = $urandom_range(0, 63 - nv);
      send_beat(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      for (int i = 0; i < ne; i++)
         send_beat(OP_ADD, base + $urandom_range(0, nv-1), base + $urandom_range(0, nv-1),
                   rand_cap());
      for (int i = 0; i < nsolve; i++)
         send_beat(OP_SOLVE, base + $urandom_range(0, nv-1), base + $urandom_range(0, nv-1),
                   $urandom);
   endtask

   // --------------------------------------------------------------------------
   // Response side
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_rsp(rsp_data);
   end

   initial begin
      int wait_cnt;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_hold = 0;
         end
         wait_cnt = $urandom_range(0, 7);
         if (wait_cnt != 0 && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cnt) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      sb        = new();
      rsp_hold  = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, source==sink, self loop, extremes, unused op
      send_beat(OP_SOLVE, 0, 63, 0);
      send_beat(OP_ADD, 0, 1, 24'hFFFFFF);
      send_beat(OP_ADD, 1, 63, 24'hFFFFFF);
      send_beat(OP_ADD, 0, 63, 24'hFFFFFF);
      send_beat(OP_ADD, 5, 5, 100);
      send_beat(OP_ADD, 63, 0, 0);
      send_beat(2'd3, 63, 63, 24'hFFFFFF);
      send_beat(OP_SOLVE, 5, 5, 0);
      send_beat(OP_SOLVE, 0, 63, 24'hFFFFFF);
      send_beat(OP_SOLVE, 0, 63, 0);
      send_beat(OP_SOLVE, 63, 0, 0);
      // fill the edge table and overflow it
      send_beat(OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < EDGES + 3; i++)
         send_beat(OP_ADD, i % 4, (i % 4) + 1, 24'hFFFFFF);
      send_beat(OP_SOLVE, 0, 4, 0);
      send_beat(OP_CLEAR, 0, 0, 0);
      send_beat(OP_SOLVE, 0, 4, 0);

      // receiver stalls long while solves pile up
      rsp_hold = 1;
      graph_round(4, 6, 5);
      wait_drained();

      for (int r = 0; r < 34; r++) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         graph_round($urandom_range(2, 10), $urandom_range(1, 14), $urandom_range(1, 4));
         if (r == 20) wait_drained();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("max_flow_augmenting_path: match");
      end else begin
         $display("max_flow_augmenting_path: mismatch");
      end
      $finish;
   end

endmodule
